// ===== sv/dcrc_pkg.sv =====
`timescale 1ns / 1ps

package dcrc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC12_W = 12;
    localparam int unsigned CRC14_W = 14;
    localparam int unsigned TRL_W   = 32;
    localparam int unsigned PAD_W   = TRL_W - CRC12_W - CRC14_W;
    localparam int unsigned HALF12  = CRC12_W / 2;

    localparam logic [CRC12_W-1:0] CRC12_POLY       = 12'h80F;
    localparam logic [CRC14_W-1:0] CRC14_POLY_RESET = 14'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_trailer;
        logic              last;
    } out_word_t;

    function automatic logic [CRC12_W-1:0] crc12_byte(
        input logic [CRC12_W-1:0] crc,
        input logic [BYTE_W-1:0]  data
    );
        logic [CRC12_W-1:0] c;
        logic               fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = data[i] ^ c[CRC12_W-1];
            c  = {c[CRC12_W-2:0], 1'b0} ^ (fb ? CRC12_POLY : '0);
        end
        return c;
    endfunction

    function automatic logic [CRC14_W-1:0] crc14_byte(
        input logic [CRC14_W-1:0] crc,
        input logic [BYTE_W-1:0]  data,
        input logic [CRC14_W-1:0] taps
    );
        logic [CRC14_W-1:0] c;
        logic               fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = data[i] ^ c[CRC14_W-1];
            c  = {c[CRC14_W-2:0], 1'b0} ^ (fb ? taps : '0);
        end
        return c;
    endfunction

    function automatic logic [CRC14_W-1:0] crc14_half(
        input logic [CRC14_W-1:0] crc,
        input logic [HALF12-1:0]  data,
        input logic [CRC14_W-1:0] taps
    );
        logic [CRC14_W-1:0] c;
        logic               fb;
        c = crc;
        for (int i = HALF12 - 1; i >= 0; i--)
        begin
            fb = data[i] ^ c[CRC14_W-1];
            c  = {c[CRC14_W-2:0], 1'b0} ^ (fb ? taps : '0);
        end
        return c;
    endfunction

endpackage

// ===== sv/dual_crc12_crc14_trailer_top.sv =====
`timescale 1ns / 1ps

// Passes message bytes through, most significant bit first into a CRC-12
// (polynomial 0x80F) and a CRC-14 whose taps come from the poly register, and
// appends a four-byte trailer (CRC-12, CRC-14 over the message and the CRC-12,
// six zero pad bits) after the byte marked end_of_message. One byte is taken
// per cycle while the input is not stalled, each word appearing at the output
// in the cycle after acceptance. After the final byte of a frame the input
// is stalled while ST_MIX_HI and ST_MIX_LO fold the CRC-12 into the CRC-14,
// six bits a cycle, and while ST_EMIT sends the four trailer words, one per
// cycle as the output takes them. Both CRC registers are cleared for the next
// frame. The poly register should be written only between frames.
module dual_crc12_crc14_trailer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                poly_we,
    input  logic [dcrc_pkg::CRC14_W-1:0]        poly_wdata,
    input  logic                                data_valid,
    output logic                                data_stall,
    input  dcrc_pkg::in_word_t                  data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output dcrc_pkg::out_word_t                 result
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_MIX_HI,
        ST_MIX_LO,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [dcrc_pkg::CRC14_W-1:0]    poly_reg, poly_next;
    logic [dcrc_pkg::CRC12_W-1:0]    crc12_reg, crc12_next;
    logic [dcrc_pkg::CRC14_W-1:0]    crc14_reg, crc14_next;
    logic [dcrc_pkg::TRL_W-1:0]      trailer_reg, trailer_next;
    logic [1:0]                      idx_reg, idx_next;
    logic                            res_valid_reg, res_valid_next;
    dcrc_pkg::out_word_t             res_reg, res_next;

    logic                            out_free;
    logic                            in_acc;
    logic [dcrc_pkg::CRC14_W-1:0]    taps;
    logic [dcrc_pkg::CRC14_W-1:0]    crc14_fold;

    assign out_free     = !res_valid_reg || !result_stall;
    assign data_stall   = !out_free || (state_reg != ST_IDLE);
    assign in_acc       = data_valid && !data_stall;
    assign taps         = {poly_reg[dcrc_pkg::CRC14_W-1:1], 1'b1};
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign crc14_fold   = dcrc_pkg::crc14_half(crc14_reg,
                              crc12_reg[dcrc_pkg::HALF12-1:0], taps);

    always_comb
    begin
        state_next     = state_reg;
        poly_next      = poly_we ? poly_wdata : poly_reg;
        crc12_next     = crc12_reg;
        crc14_next     = crc14_reg;
        trailer_next   = trailer_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    crc12_next          = dcrc_pkg::crc12_byte(crc12_reg, data.data_byte);
                    crc14_next          = dcrc_pkg::crc14_byte(crc14_reg, data.data_byte,
                                                               taps);
                    res_valid_next      = 1'b1;
                    res_next.out_byte   = data.data_byte;
                    res_next.is_trailer = 1'b0;
                    res_next.last       = 1'b0;
                    if (data.end_of_message)
                    begin
                        state_next = ST_MIX_HI;
                    end
                end
            end
            ST_MIX_HI:
            begin
                crc14_next = dcrc_pkg::crc14_half(crc14_reg,
                    crc12_reg[dcrc_pkg::CRC12_W-1:dcrc_pkg::HALF12], taps);
                state_next = ST_MIX_LO;
            end
            ST_MIX_LO:
            begin
                trailer_next = {crc12_reg, crc14_fold, {dcrc_pkg::PAD_W{1'b0}}};
                crc12_next   = '0;
                crc14_next   = '0;
                idx_next     = '0;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next      = 1'b1;
                    res_next.out_byte   = trailer_reg[dcrc_pkg::TRL_W-1 -: dcrc_pkg::BYTE_W];
                    res_next.is_trailer = 1'b1;
                    res_next.last       = (idx_reg == 2'd3);
                    trailer_next        = trailer_reg << dcrc_pkg::BYTE_W;
                    idx_next            = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            poly_reg      <= dcrc_pkg::CRC14_POLY_RESET;
            crc12_reg     <= '0;
            crc14_reg     <= '0;
            trailer_reg   <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            poly_reg      <= poly_next;
            crc12_reg     <= crc12_next;
            crc14_reg     <= crc14_next;
            trailer_reg   <= trailer_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    // The final trailer word is loaded on the same edge that returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> (result.is_trailer && state_reg == ST_IDLE))
        else $error("last word without trailer or outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && data.end_of_message) |=> (state_reg == ST_MIX_HI))
        else $error("final byte did not start the trailer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> data_stall)
        else $error("input taken while trailer pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX_LO) |=> (crc12_reg == '0 && crc14_reg == '0))
        else $error("CRC registers not cleared after frame");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_GAP    = 10;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 380;

    class trailer_scoreboard;
        logic [dcrc_pkg::CRC14_W-1:0] poly;
        logic [dcrc_pkg::CRC12_W-1:0] crc12;
        logic [dcrc_pkg::CRC14_W-1:0] crc14;
        dcrc_pkg::out_word_t          expected_words[$];
        int                           errors;
        int                           frames;
        int                           bytes_taken;
        int                           words_checked;

        function new();
            poly          = dcrc_pkg::CRC14_POLY_RESET;
            crc12         = '0;
            crc14         = '0;
            errors        = 0;
            frames        = 0;
            bytes_taken   = 0;
            words_checked = 0;
        endfunction

        function void set_poly(input logic [dcrc_pkg::CRC14_W-1:0] p);
            poly = p;
        endfunction

        function void shift_crc12(input logic b);
            logic fb;
            fb    = b ^ crc12[dcrc_pkg::CRC12_W-1];
            crc12 = {crc12[dcrc_pkg::CRC12_W-2:0], 1'b0};
            if (fb)
            begin
                crc12 = crc12 ^ dcrc_pkg::CRC12_POLY;
            end
        endfunction

        function void shift_crc14(input logic b);
            logic fb;
            fb    = b ^ crc14[dcrc_pkg::CRC14_W-1];
            crc14 = {crc14[dcrc_pkg::CRC14_W-2:0], 1'b0};
            if (fb)
            begin
                crc14 = crc14 ^ (poly | 14'd1);
            end
        endfunction

        function void note_byte(input dcrc_pkg::in_word_t w);
            dcrc_pkg::out_word_t        e;
            logic [dcrc_pkg::TRL_W-1:0] trailer;
            int                         i;
            bytes_taken++;
            for (i = dcrc_pkg::BYTE_W - 1; i >= 0; i--)
            begin
                shift_crc12(w.data_byte[i]);
                shift_crc14(w.data_byte[i]);
            end
            e.out_byte   = w.data_byte;
            e.is_trailer = 1'b0;
            e.last       = 1'b0;
            expected_words.push_back(e);
            if (w.end_of_message)
            begin
                for (i = dcrc_pkg::CRC12_W - 1; i >= 0; i--)
                begin
                    shift_crc14(crc12[i]);
                end
                trailer = {crc12, crc14, {dcrc_pkg::PAD_W{1'b0}}};
                for (i = 3; i >= 0; i--)
                begin
                    e.out_byte   = trailer[i*dcrc_pkg::BYTE_W +: dcrc_pkg::BYTE_W];
                    e.is_trailer = 1'b1;
                    e.last       = (i == 0);
                    expected_words.push_back(e);
                end
                crc12 = '0;
                crc14 = '0;
                frames++;
            end
        endfunction

        function void check_word(input dcrc_pkg::out_word_t w);
            dcrc_pkg::out_word_t e;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_byte %0h is_trailer %0b last %0b",
                       w.out_byte, w.is_trailer, w.last);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            words_checked++;
            if (w.out_byte !== e.out_byte)
            begin
                $error("out_byte mismatch: expected %0h, actual %0h", e.out_byte, w.out_byte);
                errors++;
            end
            if (w.is_trailer !== e.is_trailer)
            begin
                $error("is_trailer mismatch: expected %0b, actual %0b",
                       e.is_trailer, w.is_trailer);
                errors++;
            end
            if (w.last !== e.last)
            begin
                $error("last mismatch: expected %0b, actual %0b", e.last, w.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          poly_we;
    logic [dcrc_pkg::CRC14_W-1:0]  poly_wdata;
    logic                          data_valid;
    logic                          data_stall;
    dcrc_pkg::in_word_t            data;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    dcrc_pkg::out_word_t           result;

    trailer_scoreboard   sb;
    int                  burst_left;
    int                  bytes_sent;
    int                  poly_settings;
    int                  idle_cycles = 0;
    logic [8:0]          stall_tick  = '0;

    dual_crc12_crc14_trailer_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .poly_we      (poly_we),
        .poly_wdata   (poly_wdata),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data         (data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && data_valid && !data_stall)
        begin
            sb.note_byte(data);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_word(result);
        end
    end

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 9'd1;
        case (stall_tick[8:7])
            2'd0:    result_stall <= 1'b0;
            2'd1:    result_stall <= ($urandom_range(0, 99) < 30);
            2'd2:    result_stall <= ($urandom_range(0, 99) < 70);
            default: result_stall <= (stall_tick[1:0] != 2'b00);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (data_valid && !data_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [dcrc_pkg::BYTE_W-1:0] b, input logic eom);
        dcrc_pkg::in_word_t w;
        w.data_byte      = b;
        w.end_of_message = eom;
        data_valid <= 1'b1;
        data       <= w;
        @(posedge clk);
        while (data_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic send_frame(input int len);
        int                            i;
        logic [dcrc_pkg::BYTE_W-1:0]   b;
        for (i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(b, i == len - 1);
        end
    endtask

    // The extra edge lets the monitor record the word accepted at this edge.
    task automatic wait_drained();
        data_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_poly(input logic [dcrc_pkg::CRC14_W-1:0] p);
        poly_we    <= 1'b1;
        poly_wdata <= p;
        @(posedge clk);
        poly_we <= 1'b0;
        sb.set_poly(p);
        poly_settings++;
    endtask

    initial
    begin
        logic [dcrc_pkg::CRC14_W-1:0] p;
        int                           phase;
        int                           target;
        sb            = new();
        burst_left    = 5;
        bytes_sent    = 0;
        poly_settings = 1;
        rst_n        <= 1'b0;
        poly_we      <= 1'b0;
        poly_wdata   <= '0;
        data_valid   <= 1'b0;
        data         <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte frames and a short frame under the reset polynomial.
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b1);
        wait_drained();
        write_poly(14'h3FFF);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        wait_drained();
        write_poly(14'h0000);
        send_word(8'h00, 1'b0);
        send_word(8'hA5, 1'b1);

        // The polynomial is changed part-way through this frame.
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        wait_drained();
        write_poly(14'h2A6B);
        send_word(8'h56, 1'b0);
        send_word(8'hC3, 1'b1);
        wait_drained();
        write_poly(14'h1554);
        send_word(8'h7E, 1'b1);

        target = bytes_sent + RANDOM_ITEMS;
        phase  = 0;
        while (bytes_sent < target)
        begin
            case (phase)
                0:       p = 14'h3FFF;
                1:       p = 14'h0000;
                2:       p = dcrc_pkg::CRC14_POLY_RESET;
                3:       p = 14'h2000;
                default: p = 14'($urandom_range(0, 16383));
            endcase
            wait_drained();
            write_poly(p);
            repeat ($urandom_range(3, 6))
            begin
                send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                       : $urandom_range(1, 8));
            end
            phase++;
        end

        wait_drained();
        if (sb.pending() != 0)
        begin
            $error("%0d expected words never arrived", sb.pending());
        end
        $display("Sent %0d bytes in %0d frames and checked %0d output words.",
                 bytes_sent, sb.frames, sb.words_checked);
        $display("Used %0d polynomial settings, including all-zero and all-one taps.",
                 poly_settings);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
